/* rtl/core/fft256_pkg.sv */
package fft256_pkg;

	localparam int SampleBits = 16;
	localparam int StoreBits  = 25;
	localparam int OutBits    = 24;
	localparam int TwBits     = 18;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Controller to datapath.
	typedef struct packed {
		logic load_wr;     // write input sample at load address
		logic bfly_rd;     // read a butterfly pair
		logic wr_a;        // write back the first entry of the pair
		logic wr_b;        // write back the second entry of the pair
		logic swap;        // write the pair exchanged instead of the butterfly
		logic out_rd;      // read one bin for readout
	} fft256_cmd_t;

	typedef struct packed {
		logic out_valid;
	} fft256_sts_t;

	// Q1.16 twiddle rounded half up from the exact angle; step is one
	// twiddle step in radians. Evaluated only at elaboration.
	function automatic logic signed [TwBits-1:0] tw_cos(input int k, input real step);
		real a;
		a = step * k;
		return TwBits'($rtoi($floor(65536.0 * $cos(a) + 0.5)));
	endfunction

	function automatic logic signed [TwBits-1:0] tw_nsin(input int k, input real step);
		real a;
		a = step * k;
		return TwBits'(-$rtoi($floor(65536.0 * $sin(a) + 0.5)));
	endfunction

	function automatic logic signed [StoreBits-1:0] sat_store(input logic signed [StoreBits+1:0] v);
		logic signed [StoreBits+1:0] hi;
		logic signed [StoreBits+1:0] lo;
		hi = (StoreBits+2)'((1 <<< (StoreBits-1)) - 1);
		lo = -hi - 1;
		if (v > hi) return hi[StoreBits-1:0];
		else if (v < lo) return lo[StoreBits-1:0];
		else return v[StoreBits-1:0];
	endfunction

endpackage

/* rtl/core/fft256_ctrl.sv */
module fft256_ctrl #(
	parameter int POINTS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_op,
	output logic                  in_ready,
	input  logic                  out_busy,
	output fft256_pkg::fft256_cmd_t cmd,
	output logic [$clog2(POINTS)-1:0] addr_a,
	output logic [$clog2(POINTS)-1:0] addr_b,
	output logic [$clog2(POINTS)-2:0] tw_idx,
	output logic                  last_bin
);
	import fft256_pkg::*;

	localparam int LogN = $clog2(POINTS);

	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_REV   = 5'b00010,
		ST_BFLY  = 5'b00100,
		ST_SHIFT = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [LogN-1:0] pair_q;
	logic [$clog2(LogN+1)-1:0] stage_q;
	logic [1:0]      phase_q;
	logic            accept;
	logic [LogN-1:0] rev;
	logic [LogN-1:0] half;
	logic [LogN-1:0] lowm;
	logic [LogN-1:0] aidx;

	assign accept = in_valid && in_ready;
	// During readout a tick is taken only when the previous bin has left its
	// read cycle and the output register is free or being emptied.
	assign in_ready = (state_q == ST_LOAD) || (state_q == ST_OUT && !out_busy && phase_q == 2'd0);

	always_comb begin
		for (int b = 0; b < LogN; b++) rev[b] = pair_q[LogN-1-b];
	end

	// Butterfly index: insert a zero at bit (stage-1) of the pair counter.
	always_comb begin
		half = LogN'(1) << (stage_q - 1'b1);
		lowm = half - 1'b1;
		aidx = ((pair_q & ~lowm) << 1) | (pair_q & lowm);
	end

	always_comb begin
		cmd = '0;
		addr_a = pair_q;
		addr_b = pair_q;
		tw_idx = '0;
		last_bin = (pair_q == LogN'(POINTS - 1));
		case (state_q)
			ST_LOAD: begin
				cmd.load_wr = accept && in_op == OP_LOAD;
			end
			ST_REV: begin
				addr_a = pair_q;
				addr_b = rev;
				cmd.swap = 1'b1;
				cmd.bfly_rd = phase_q == 2'd0;
				cmd.wr_a = phase_q == 2'd2 && rev > pair_q;
				cmd.wr_b = phase_q == 2'd3 && rev > pair_q;
			end
			ST_BFLY: begin
				addr_a = aidx;
				addr_b = aidx | half;
				tw_idx = (LogN-1)'((pair_q & lowm) << (LogN - stage_q));
				cmd.bfly_rd = phase_q == 2'd0;
				cmd.wr_a = phase_q == 2'd2;
				cmd.wr_b = phase_q == 2'd3;
			end
			ST_SHIFT: begin
				addr_a = pair_q;
				addr_b = pair_q | LogN'(POINTS / 2);
				cmd.swap = 1'b1;
				cmd.bfly_rd = phase_q == 2'd0;
				cmd.wr_a = phase_q == 2'd2;
				cmd.wr_b = phase_q == 2'd3;
			end
			ST_OUT: begin
				cmd.out_rd = accept && in_op == OP_TICK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pair_q  <= '0;
			stage_q <= '0;
			phase_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept && in_op == OP_LOAD) begin
						if (pair_q == LogN'(POINTS - 1)) begin
							state_q <= ST_REV;
							pair_q  <= '0;
							phase_q <= '0;
						end else begin
							pair_q <= pair_q + 1'b1;
						end
					end
				end
				ST_REV, ST_BFLY, ST_SHIFT: begin
					// Each pair: read, wait for the registered read, then write
					// back one entry per cycle.
					phase_q <= phase_q + 1'b1;
					if (phase_q == 2'd3) begin
						if (state_q == ST_REV && pair_q == LogN'(POINTS - 1)) begin
							state_q <= ST_BFLY;
							pair_q  <= '0;
							stage_q <= ($clog2(LogN+1))'(1);
						end else if (state_q != ST_REV && pair_q == LogN'(POINTS / 2 - 1)) begin
							pair_q <= '0;
							if (state_q == ST_SHIFT) state_q <= ST_OUT;
							else if (stage_q == ($clog2(LogN+1))'(LogN)) state_q <= ST_SHIFT;
							else stage_q <= stage_q + 1'b1;
						end else begin
							pair_q <= pair_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					phase_q <= (accept && in_op == OP_TICK) ? 2'd1 : 2'd0;
					if (accept && in_op == OP_TICK) begin
						if (pair_q == LogN'(POINTS - 1)) begin
							state_q <= ST_LOAD;
							pair_q  <= '0;
						end else begin
							pair_q <= pair_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_wr || cmd.out_rd) |-> !(cmd.bfly_rd || cmd.wr_a || cmd.wr_b))
		else $error("stream access during transform");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_a |-> $past(cmd.bfly_rd, 2))
		else $error("first write-back without matching read");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_b |-> $past(cmd.bfly_rd, 3))
		else $error("second write-back without matching read");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BFLY) |-> (addr_a != addr_b))
		else $error("butterfly addresses collide");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");

endmodule

/* rtl/core/fft256_dp.sv */
module fft256_dp #(
	parameter int POINTS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fft256_pkg::fft256_cmd_t cmd,
	input  logic [$clog2(POINTS)-1:0] addr_a,
	input  logic [$clog2(POINTS)-1:0] addr_b,
	input  logic [$clog2(POINTS)-2:0] tw_idx,
	input  logic                  last_bin,
	input  logic signed [15:0]    sample_re,
	input  logic signed [15:0]    sample_im,
	input  logic                  out_ready,
	output fft256_pkg::fft256_sts_t sts,
	output logic [55:0]           out_data,
	output logic                  out_last
);
	import fft256_pkg::*;

	localparam int LogN = $clog2(POINTS);
	localparam real TwStep = 2.0 * 3.14159265358979323846 / POINTS;

	// Two banks holding the same data give two read ports; writes go to both.
	logic [2*StoreBits-1:0] mem_a [POINTS];
	logic [2*StoreBits-1:0] mem_b [POINTS];
	logic [2*StoreBits-1:0] rd_a_s1, rd_b_s1;
	logic [LogN-2:0] tw_s1;
	logic            rd_s1;
	logic signed [TwBits-1:0] tw_re_rom [POINTS/2];
	logic signed [TwBits-1:0] tw_im_rom [POINTS/2];
	logic signed [StoreBits-1:0] br, bi;
	logic signed [TwBits-1:0] wr, wi;
	logic signed [StoreBits+TwBits-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [StoreBits-1:0] ar_s2, ai_s2;
	logic [2*StoreBits-1:0] swap_a_s2, swap_b_s2;
	logic signed [StoreBits+TwBits:0] sum_r, sum_i;
	logic signed [StoreBits+2:0] tr, ti;
	logic [2*StoreBits-1:0] wa, wb;
	logic            wr_en;
	logic [LogN-1:0] wr_addr;
	logic [2*StoreBits-1:0] wr_data;
	logic [LogN-1:0] ra_q, rb_q;
	logic            out_valid_q;
	logic signed [StoreBits-1:0] o_re, o_im;
	logic [LogN-1:0] pos_s1;
	logic            last_s1;
	logic signed [OutBits-1:0] sr, si;

	always_comb begin
		for (int k = 0; k < POINTS/2; k++) begin
			tw_re_rom[k] = tw_cos(k, TwStep);
			tw_im_rom[k] = tw_nsin(k, TwStep);
		end
	end

	// One write per cycle: a loaded sample, or one entry of a pair.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_a;
		wr_data = {StoreBits'(sample_im), StoreBits'(sample_re)};
		if (cmd.load_wr) begin
			wr_en = 1'b1;
		end else if (cmd.wr_a) begin
			wr_en   = 1'b1;
			wr_addr = ra_q;
			wr_data = cmd.swap ? swap_a_s2 : wa;
		end else if (cmd.wr_b) begin
			wr_en   = 1'b1;
			wr_addr = rb_q;
			wr_data = cmd.swap ? swap_b_s2 : wb;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bfly_rd || cmd.out_rd) begin
			rd_a_s1 <= mem_a[addr_a];
			rd_b_s1 <= mem_b[addr_b];
		end
		if (wr_en) begin
			mem_a[wr_addr] <= wr_data;
			mem_b[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bfly_rd) begin
			ra_q <= addr_a;
			rb_q <= addr_b;
		end
		tw_s1   <= tw_idx;
		pos_s1  <= addr_a;
		last_s1 <= last_bin;
	end

	assign br = rd_b_s1[StoreBits-1:0];
	assign bi = rd_b_s1[2*StoreBits-1:StoreBits];
	assign wr = tw_re_rom[tw_s1];
	assign wi = tw_im_rom[tw_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.out_rd;
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s2   <= wr * br;
		p_ii_s2   <= wi * bi;
		p_ri_s2   <= wr * bi;
		p_ir_s2   <= wi * br;
		ar_s2     <= rd_a_s1[StoreBits-1:0];
		ai_s2     <= rd_a_s1[2*StoreBits-1:StoreBits];
		swap_a_s2 <= rd_b_s1;
		swap_b_s2 <= rd_a_s1;
	end

	always_comb begin
		sum_r = (StoreBits+TwBits+1)'(p_rr_s2) - (StoreBits+TwBits+1)'(p_ii_s2) + 32768;
		sum_i = (StoreBits+TwBits+1)'(p_ri_s2) + (StoreBits+TwBits+1)'(p_ir_s2) + 32768;
		tr = (StoreBits+3)'(sum_r >>> 16);
		ti = (StoreBits+3)'(sum_i >>> 16);
	end

	always_comb begin
		wa = {sat_store((StoreBits+2)'(ai_s2) + (StoreBits+2)'(ti)),
		      sat_store((StoreBits+2)'(ar_s2) + (StoreBits+2)'(tr))};
		wb = {sat_store((StoreBits+2)'(ai_s2) - (StoreBits+2)'(ti)),
		      sat_store((StoreBits+2)'(ar_s2) - (StoreBits+2)'(tr))};
	end

	assign o_re = rd_a_s1[StoreBits-1:0];
	assign o_im = rd_a_s1[2*StoreBits-1:StoreBits];
	assign sr = (o_re > 25'sd8388607) ? 24'sh7FFFFF : (o_re < -25'sd8388608) ? 24'sh800000
		: o_re[OutBits-1:0];
	assign si = (o_im > 25'sd8388607) ? 24'sh7FFFFF : (o_im < -25'sd8388608) ? 24'sh800000
		: o_im[OutBits-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (rd_s1) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			out_data <= {8'(pos_s1), si, sr};
			out_last <= last_s1;
		end
	end

	assign sts.out_valid = out_valid_q;

endmodule

/* rtl/core/fft_256_with_shift.sv */
// 256-point radix-2 DIT FFT with fftshift. Load POINTS sample requests
// (tuser=0), one per cycle; ticks while loading are ignored. The last sample
// starts the transform, during which the input is not ready. It runs a
// bit-reverse pass, log2(POINTS) butterfly stages and a half swap; each
// pair goes through one registered memory read, one multiply stage and two
// write-backs, since each memory bank has a single write port. Ticks
// (tuser=1) then read one bin each, bin POINTS/2 first; a new tick is taken
// only when the previous bin has left its read cycle and the output register
// is free or being emptied. Each bin passes the memory read register and the
// output register. Samples during readout are dropped.
module fft_256_with_shift #(
	parameter int POINTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample_re[15:0], sample_im[31:16]
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // bin_re[23:0], bin_im[47:24], bin_pos[55:48]
	output logic        m_tlast    // last
);
	import fft256_pkg::*;

	fft256_cmd_t cmd;
	fft256_sts_t sts;
	logic [$clog2(POINTS)-1:0] addr_a, addr_b;
	logic [$clog2(POINTS)-2:0] tw_idx;
	logic last_bin;

	fft256_ctrl #(.POINTS(POINTS)) u_ctrl (
		.clk, .arst_n, .in_valid(s_tvalid), .in_op(s_tuser), .in_ready(s_tready),
		.out_busy(sts.out_valid && !m_tready), .cmd, .addr_a, .addr_b, .tw_idx, .last_bin
	);

	fft256_dp #(.POINTS(POINTS)) u_dp (
		.clk, .arst_n, .cmd, .addr_a, .addr_b, .tw_idx, .last_bin,
		.sample_re(s_tdata[15:0]), .sample_im(s_tdata[31:16]),
		.out_ready(m_tready), .sts, .out_data(m_tdata), .out_last(m_tlast)
	);

	assign m_tvalid = sts.out_valid;

endmodule
